>>> hw/rtl/sgc_pkg.sv
// ----------------------------------------------------------------------------
// Stroke gesture classifier package
// Shared constants, gesture codes and the arctangent step table.
// ----------------------------------------------------------------------------
`default_nettype none
package sgc_pkg;

  localparam int CoordWidth = 30;
  localparam int AtanEntries = 24;

  typedef enum logic [2:0] {
    GEST_RIGHT  = 3'd0,
    GEST_LEFT   = 3'd1,
    GEST_DOWN   = 3'd2,
    GEST_UP     = 3'd3,
    GEST_CIRC_P = 3'd4,
    GEST_CIRC_N = 3'd5
  } gesture_t;

  typedef enum logic [1:0] {
    REG_MIN_POINTS = 2'd0,
    REG_TIMEOUT_MS = 2'd1
  } reg_index_t;

  typedef logic [31:0] atan_tab_t [AtanEntries];

  localparam atan_tab_t AtanTab = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic [31:0] atan_step(input int stage, input int abits);
    logic [32:0] t;
    t = {1'b0, AtanTab[stage % AtanEntries]} + (33'd1 << (31 - abits));
    return t[32:1] >> (31 - abits);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sgc_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One registered rotation step of the heading chain.
// ----------------------------------------------------------------------------
`default_nettype none
module sgc_cordic_cell #(
  parameter int ANGLE_BITS = 16,
  parameter int STAGE = 0
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      in_valid,
  input  wire                                      in_zero,
  input  wire logic signed [sgc_pkg::CoordWidth-1:0] in_x,
  input  wire logic signed [sgc_pkg::CoordWidth-1:0] in_y,
  input  wire logic [ANGLE_BITS-1:0]               in_z,
  output logic                                     out_valid,
  output logic                                     out_zero,
  output logic signed [sgc_pkg::CoordWidth-1:0]    out_x,
  output logic signed [sgc_pkg::CoordWidth-1:0]    out_y,
  output logic [ANGLE_BITS-1:0]                    out_z
);

  localparam logic [ANGLE_BITS-1:0] Step =
    ANGLE_BITS'(sgc_pkg::atan_step(STAGE, ANGLE_BITS));

  logic signed [sgc_pkg::CoordWidth-1:0] xs;
  logic signed [sgc_pkg::CoordWidth-1:0] ys;

  assign xs = in_x >>> STAGE;
  assign ys = in_y >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_zero <= in_zero;
    if (in_y > 0) begin
      out_x <= in_x + ys;
      out_y <= in_y - xs;
      out_z <= in_z + Step;
    end else begin
      out_x <= in_x - ys;
      out_y <= in_y + xs;
      out_z <= in_z - Step;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sgc_cordic.sv
// ----------------------------------------------------------------------------
// Segment heading unit
// Half-turn pre-rotation followed by a chain of CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none
module sgc_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire logic signed [9:0]   dx,
  input  wire logic signed [8:0]   dy,
  output logic                     done,
  output logic [ANGLE_BITS-1:0]    heading
);

  localparam int Cw = sgc_pkg::CoordWidth;

  logic              v_c [ANGLE_BITS+1];
  logic              zr_c [ANGLE_BITS+1];
  logic signed [Cw-1:0] x_c [ANGLE_BITS+1];
  logic signed [Cw-1:0] y_c [ANGLE_BITS+1];
  logic [ANGLE_BITS-1:0] z_c [ANGLE_BITS+1];

  logic signed [Cw-1:0] xin;
  logic signed [Cw-1:0] yin;

  assign xin = Cw'(dx) <<< 16;
  assign yin = Cw'(dy) <<< 16;

  assign v_c[0]  = start;
  assign zr_c[0] = (dx == 10'sd0) && (dy == 9'sd0);
  assign x_c[0]  = dx[9] ? -xin : xin;
  assign y_c[0]  = dx[9] ? -yin : yin;
  assign z_c[0]  = dx[9] ? (ANGLE_BITS'(1) << (ANGLE_BITS - 1)) : '0;

  for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_cell
    sgc_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .STAGE(i)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(v_c[i]), .in_zero(zr_c[i]),
      .in_x(x_c[i]), .in_y(y_c[i]), .in_z(z_c[i]),
      .out_valid(v_c[i+1]), .out_zero(zr_c[i+1]),
      .out_x(x_c[i+1]), .out_y(y_c[i+1]), .out_z(z_c[i+1])
    );
  end

  assign done    = v_c[ANGLE_BITS];
  assign heading = zr_c[ANGLE_BITS] ? '0 : z_c[ANGLE_BITS];

endmodule
`default_nettype wire

>>> hw/rtl/stroke_gesture_classifier.sv
// ----------------------------------------------------------------------------
// Stroke gesture classifier
// A point that opens a stroke goes from the taken request straight to the done
// state; later points first pass through the CORDIC cell chain.
// Points are handled one at a time, each only once the last is through; a
// gesture still waiting on the output holds back the next gesture.
// Reset: stroke empty, last time 0, min_points 10, timeout_ms 1000.
// ----------------------------------------------------------------------------
`default_nettype none
module stroke_gesture_classifier #(
  parameter int ANGLE_BITS = 16,
  parameter int MAX_POINTS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [8:0]   x_pos,
  input  wire [7:0]   y_pos,
  input  wire [31:0]  time_ms,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  gesture,
  output logic signed [9:0] net_dx,
  output logic signed [8:0] net_dy,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [15:0]  cfg_data
);

  localparam int Cw = $clog2(MAX_POINTS + 1);
  localparam logic [24:0] HalfTurn = 25'(1) << (ANGLE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  logic [6:0]  min_points;
  logic [15:0] timeout_ms;
  logic [Cw-1:0] point_count;
  logic signed [22:0] turn_sum;
  logic [31:0] last_time;
  logic [8:0]  first_x, prev_x, cur_x;
  logic [7:0]  first_y, prev_y, cur_y;
  logic [ANGLE_BITS-1:0] prev_heading, cur_heading;

  logic accept, timed_out, cstart, cdone;
  logic [31:0] elapsed;
  logic [Cw-1:0] cnt_eff, cnt_next;
  logic signed [9:0] dx;
  logic signed [8:0] dy;
  logic [ANGLE_BITS-1:0] heading;
  logic [ANGLE_BITS-1:0] dh;
  logic signed [25:0] tsum;
  logic signed [22:0] turn_next;
  logic signed [23:0] tabs;
  logic emit, stall;
  logic [8:0] fx;
  logic [7:0] fy;
  logic signed [9:0] ndx;
  logic signed [8:0] ndy;
  logic [10:0] adx, ady;
  logic [2:0] gest_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign elapsed   = time_ms - last_time;
  assign timed_out = elapsed > {16'd0, timeout_ms};
  assign cnt_eff   = timed_out ? '0 : point_count;
  assign dx        = 10'({1'b0, x_pos}) - 10'({1'b0, prev_x});
  assign dy        = 9'({1'b0, y_pos}) - 9'({1'b0, prev_y});
  assign cstart    = accept && (cnt_eff != '0);

  sgc_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .dx(dx), .dy(dy),
    .done(cdone), .heading(heading)
  );

  always_comb begin
    dh = cur_heading - prev_heading;
    tsum = 26'(turn_sum) + 26'($signed(dh));
    if (point_count < Cw'(2)) begin
      turn_next = turn_sum;
    end else if (tsum > 26'sd4194303) begin
      turn_next = 23'sd4194303;
    end else if (tsum < -26'sd4194304) begin
      turn_next = -23'sd4194304;
    end else begin
      turn_next = 23'(tsum);
    end
    tabs = turn_next[22] ? -24'(turn_next) : 24'(turn_next);
    cnt_next = point_count + Cw'(1);
    emit = (32'(cnt_next) >= 32'(min_points)) || (32'(cnt_next) >= 32'(MAX_POINTS));
    fx = (point_count == '0) ? cur_x : first_x;
    fy = (point_count == '0) ? cur_y : first_y;
    ndx = 10'({1'b0, cur_x}) - 10'({1'b0, fx});
    ndy = 9'({1'b0, cur_y}) - 9'({1'b0, fy});
    adx = ndx[9] ? -11'(ndx) : 11'(ndx);
    ady = ndy[8] ? -11'(ndy) : 11'(ndy);
    if (adx > ady) begin
      gest_next = (ndx > 10'sd0) ? sgc_pkg::GEST_RIGHT : sgc_pkg::GEST_LEFT;
    end else begin
      gest_next = (ndy > 9'sd0) ? sgc_pkg::GEST_DOWN : sgc_pkg::GEST_UP;
    end
    if (25'(tabs) > HalfTurn) begin
      gest_next = turn_next[22] ? sgc_pkg::GEST_CIRC_N : sgc_pkg::GEST_CIRC_P;
    end
    stall = emit && out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      min_points  <= 7'd10;
      timeout_ms  <= 16'd1000;
      point_count <= '0;
      turn_sum    <= '0;
      last_time   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          sgc_pkg::REG_MIN_POINTS: min_points <= cfg_data[6:0];
          sgc_pkg::REG_TIMEOUT_MS: timeout_ms <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && !(state == S_DONE && emit)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_time <= time_ms;
            if (timed_out) begin
              point_count <= '0;
              turn_sum    <= '0;
            end
            state <= (cnt_eff == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (cdone) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!stall) begin
            if (emit) begin
              out_valid   <= 1'b1;
              point_count <= '0;
              turn_sum    <= '0;
            end else begin
              point_count <= cnt_next;
              turn_sum    <= turn_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x <= x_pos;
      cur_y <= y_pos;
    end
    if (state == S_RUN && cdone) begin
      cur_heading <= heading;
    end
    if (state == S_DONE && !stall) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      if (point_count == '0) begin
        first_x <= cur_x;
        first_y <= cur_y;
      end else begin
        prev_heading <= cur_heading;
      end
      if (emit) begin
        gesture <= gest_next;
        net_dx  <= ndx;
        net_dy  <= ndy;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sgc_checker.sv
// ----------------------------------------------------------------------------
// Stroke gesture classifier port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module sgc_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] gesture,
  input wire [9:0] net_dx,
  input wire [8:0] net_dy
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gesture) && $stable(net_dx)
      && $stable(net_dy))
    else $error("result request changed while stalled");

  a_gest_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gesture <= 3'd5)
    else $error("gesture code out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a point is in work");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a point in work");

endmodule

bind stroke_gesture_classifier sgc_checker u_sgc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .gesture(gesture),
  .net_dx(net_dx), .net_dy(net_dy)
);
`default_nettype wire

>>> verif/stroke_gesture_classifier_tb.sv
// ----------------------------------------------------------------------------
// Stroke gesture classifier testbench
// Sends tracked points through the request channel, predicts each gesture
// and net displacement with a local CORDIC heading and turning-sum model,
// and checks every result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module stroke_gesture_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AngBits = 16;
  localparam int MaxPts = 64;
  localparam logic [31:0] AngHalf = 32'd1 << (AngBits - 1);
  localparam logic [31:0] AngMask = (32'd1 << AngBits) - 1;

  typedef struct packed {
    logic [2:0] gesture;
    logic signed [9:0] net_dx;
    logic signed [8:0] net_dy;
  } gesture_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [8:0] x_pos = '0;
  logic [7:0] y_pos = '0;
  logic [31:0] time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] gesture;
  logic signed [9:0] net_dx;
  logic signed [8:0] net_dy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  stroke_gesture_classifier u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_pos(x_pos), .y_pos(y_pos), .time_ms(time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .gesture(gesture), .net_dx(net_dx), .net_dy(net_dy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned mdl_min_pts;
  int unsigned mdl_timeout;
  int unsigned pt_count;
  int first_x, first_y, prev_x, prev_y;
  logic [31:0] prev_heading;
  longint turn_acc;
  logic [31:0] last_time;

  gesture_rec_t gesture_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int points_sent = 0;
  int circles_seen = 0;
  bit idle_on = 1'b1;
  logic [31:0] clock_ms = '0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] cordic_heading(int dx, int dy);
    longint cx, cy, xs, ys;
    logic [31:0] z, stp;
    logic [32:0] t;
    cx = longint'(dx) * 65536;
    cy = longint'(dy) * 65536;
    z = '0;
    if (dx == 0 && dy == 0) return '0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z = AngHalf;
    end
    for (int i = 0; i < AngBits && i < sgc_pkg::AtanEntries; i++) begin
      t = {1'b0, sgc_pkg::AtanTab[i]} + (33'd1 << (31 - AngBits));
      stp = t[31:0] >> (32 - AngBits);
      if (t[32]) stp = stp | (32'd1 << AngBits);
      xs = floor_shr(cx, i);
      ys = floor_shr(cy, i);
      if (cy > 0) begin
        cx = cx + ys;
        cy = cy - xs;
        z = z + stp;
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        z = z - stp;
      end
    end
    return z & AngMask;
  endfunction

  task automatic predict_point(int x, int y, logic [31:0] t);
    int unsigned lim;
    logic [31:0] h, d;
    longint sd, ats;
    int ndx, ndy, adx, ady;
    gesture_rec_t r;
    lim = (mdl_min_pts > MaxPts) ? MaxPts : mdl_min_pts;
    if ((t - last_time) > mdl_timeout) begin
      pt_count = 0;
      turn_acc = 0;
    end
    last_time = t;
    if (pt_count == 0) begin
      first_x = x;
      first_y = y;
    end else begin
      h = cordic_heading(x - prev_x, y - prev_y);
      if (pt_count >= 2) begin
        d = (h - prev_heading) & AngMask;
        sd = longint'(d);
        if (d >= AngHalf) sd = sd - (longint'(1) << AngBits);
        turn_acc = turn_acc + sd;
        if (turn_acc > 4194303) turn_acc = 4194303;
        if (turn_acc < -4194304) turn_acc = -4194304;
      end
      prev_heading = h;
    end
    prev_x = x;
    prev_y = y;
    pt_count++;
    if (pt_count >= lim) begin
      ndx = x - first_x;
      ndy = y - first_y;
      adx = ndx < 0 ? -ndx : ndx;
      ady = ndy < 0 ? -ndy : ndy;
      ats = turn_acc < 0 ? -turn_acc : turn_acc;
      if (adx > ady) r.gesture = ndx > 0 ? sgc_pkg::GEST_RIGHT : sgc_pkg::GEST_LEFT;
      else r.gesture = ndy > 0 ? sgc_pkg::GEST_DOWN : sgc_pkg::GEST_UP;
      if (ats > longint'(AngHalf))
        r.gesture = turn_acc > 0 ? sgc_pkg::GEST_CIRC_P : sgc_pkg::GEST_CIRC_N;
      r.net_dx = ndx[9:0];
      r.net_dy = ndy[8:0];
      gesture_q = {gesture_q, r};
      pt_count = 0;
      turn_acc = 0;
    end
  endtask

  task automatic send_point(int x, int y, logic [31:0] t);
    while (idle_on && $urandom_range(99) < 18) @(posedge clk);
    in_valid <= 1'b1;
    x_pos <= x[8:0];
    y_pos <= y[7:0];
    time_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(x & 9'h1FF, y & 8'hFF, t);
    points_sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (AngBits + 8) @(posedge clk);
  endtask

  task automatic write_reg(sgc_pkg::reg_index_t idx, logic [15:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == sgc_pkg::REG_MIN_POINTS) mdl_min_pts = val & 16'h7F;
    else mdl_timeout = val;
  endtask

  // advance the clock by a small step, mostly inside the timeout
  function automatic logic [31:0] tick(int unsigned lo, int unsigned hi);
    clock_ms = clock_ms + $urandom_range(hi, lo);
    return clock_ms;
  endfunction

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !idle_on || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    gesture_rec_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (gesture == sgc_pkg::GEST_CIRC_P || gesture == sgc_pkg::GEST_CIRC_N)
        circles_seen++;
      if (gesture_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result g=%0d dx=%0d dy=%0d",
                                        gesture, net_dx, net_dy);
      end else begin
        e = gesture_q.pop_front();
        if (e.gesture !== gesture || e.net_dx !== net_dx || e.net_dy !== net_dy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp g=%0d dx=%0d dy=%0d got g=%0d dx=%0d dy=%0d",
                     e.gesture, e.net_dx, e.net_dy, gesture, net_dx, net_dy);
        end
      end
    end
  end

  task automatic test_swipes();
    write_reg(sgc_pkg::REG_MIN_POINTS, 16'd3);
    write_reg(sgc_pkg::REG_TIMEOUT_MS, 16'd1000);
    send_point(0, 0, tick(1, 5));     send_point(160, 0, tick(1, 5));
    send_point(319, 0, tick(1, 5));
    send_point(319, 0, tick(1, 5));   send_point(100, 0, tick(1, 5));
    send_point(0, 0, tick(1, 5));
    send_point(0, 0, tick(1, 5));     send_point(0, 100, tick(1, 5));
    send_point(0, 239, tick(1, 5));
    send_point(0, 239, tick(1, 5));   send_point(5, 100, tick(1, 5));
    send_point(9, 0, tick(1, 5));
    // zero vectors, tie, exact reversal, out-of-range coordinates
    send_point(50, 50, tick(1, 5));   send_point(50, 50, tick(1, 5));
    send_point(50, 50, tick(1, 5));
    send_point(10, 10, tick(1, 5));   send_point(60, 10, tick(1, 5));
    send_point(10, 60, tick(1, 5));
    send_point(100, 100, tick(1, 5)); send_point(200, 100, tick(1, 5));
    send_point(100, 100, tick(1, 5));
    send_point(511, 255, tick(1, 5)); send_point(400, 250, tick(1, 5));
    send_point(511, 255, tick(1, 5));
  endtask

  task automatic test_small_min();
    write_reg(sgc_pkg::REG_MIN_POINTS, 16'd0);
    send_point(319, 239, tick(1, 5));
    write_reg(sgc_pkg::REG_MIN_POINTS, 16'd1);
    send_point(0, 0, tick(1, 5));
    write_reg(sgc_pkg::REG_MIN_POINTS, 16'd127);
    for (int i = 0; i < 64; i++) send_point(i * 5, i * 3, tick(1, 5));
  endtask

  task automatic test_timeout();
    write_reg(sgc_pkg::REG_MIN_POINTS, 16'd4);
    write_reg(sgc_pkg::REG_TIMEOUT_MS, 16'd0);
    send_point(10, 10, tick(0, 0));  send_point(20, 10, tick(0, 0));
    send_point(30, 10, tick(1, 1));  send_point(40, 10, tick(0, 0));
    write_reg(sgc_pkg::REG_TIMEOUT_MS, 16'd65535);
    send_point(1, 1, tick(65535, 65535)); send_point(2, 2, tick(65536, 65536));
    clock_ms = 32'hFFFF_FFF0;
    send_point(3, 3, clock_ms);      send_point(4, 4, tick(20, 30));
    send_point(5, 5, tick(1, 5));    send_point(6, 6, tick(1, 5));
  endtask

  // points around a circle, possibly reversed
  task automatic send_circle(int n, bit ccw);
    real a;
    int cx, cy, r;
    cx = $urandom_range(220, 100);
    cy = $urandom_range(150, 90);
    r = $urandom_range(80, 20);
    for (int i = 0; i < n; i++) begin
      a = 6.2831853 * 1.3 * i / n;
      if (!ccw) a = -a;
      send_point(cx + $rtoi(r * $cos(a)), cy + $rtoi(r * $sin(a)), tick(1, 40));
    end
  endtask

  task automatic test_random();
    int n, k;
    for (int blk = 0; blk < 70; blk++) begin
      if (blk % 15 == 0) begin
        n = $urandom_range(12, 3);
        if (blk == 30) n = 64;
        if (blk == 60) n = 100;
        write_reg(sgc_pkg::REG_MIN_POINTS, n[15:0]);
        write_reg(sgc_pkg::REG_TIMEOUT_MS,
                  (blk == 45) ? 16'd20 : 16'($urandom_range(2000, 100)));
      end
      if (blk == 20) idle_on = 1'b0;
      if (blk == 32) idle_on = 1'b1;
      if (blk == 50) drain_results();
      k = $urandom_range(3);
      if (k == 0) send_circle(mdl_min_pts, $urandom_range(1));
      else if (k == 1) begin
        for (int i = 0; i < 16; i++)
          send_point($urandom_range(511), $urandom_range(255),
                     ($urandom_range(9) == 0) ? tick(0, 70000) : tick(0, 50));
      end else begin
        n = $urandom_range(30, 4);
        for (int i = 0; i < n; i++)
          send_point(10 + i * $urandom_range(9), 200 - i * $urandom_range(6),
                     tick(1, 30));
      end
    end
  endtask

  initial begin
    mdl_min_pts = 10;
    mdl_timeout = 1000;
    pt_count = 0;
    turn_acc = 0;
    last_time = '0;
    prev_heading = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_swipes();
    test_small_min();
    test_timeout();
    test_random();
    drain_results();
    $display("Sent %0d points, checked %0d gestures (%0d circles).",
             points_sent, results_seen, circles_seen);
    $display("Covered swipes, circles, timeouts, time wrap and min_points extremes.");
    if (mismatches == 0 && gesture_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
